// ===== hdl/lesf_pkg.sv =====
// Shared constants and types for the largest empty square finder.
package lesf_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  localparam int CHAR_W = 8;
  localparam int SIZE_W = 11;
  localparam int COL_W  = 10;
  localparam int ROW_W  = 10;
  localparam int CFG_W  = 11;
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_EMPTY_CHAR = 2'd0;
  localparam logic [IDX_W-1:0] REG_COLUMNS    = 2'd1;
  localparam logic [IDX_W-1:0] REG_ROWS       = 2'd2;

  localparam logic [CHAR_W-1:0] EMPTY_CHAR_RST = 8'd46;
  localparam logic [CFG_W-1:0]  COLUMNS_RST    = 11'd1024;
  localparam logic [CFG_W-1:0]  ROWS_RST       = 11'd1024;

  localparam logic [CFG_W-1:0] MAX_COLS_C = CFG_W'(MAX_COLS);
  localparam logic [CFG_W-1:0] MAX_ROWS_C = CFG_W'(MAX_ROWS);

  // One classified map cell on its way to the back end.
  typedef struct packed {
    logic             empty;
    logic             border;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } lesf_item_t;

endpackage

// ===== hdl/largest_empty_square_finder_unit.sv =====
// Top level of the largest empty square finder.
// Throughput: one map cell per cycle, with one line buffer read and write, unless stalled.
// The last cell of a map passes through the queue and the back-end stage register before
// the result register loads; the two-entry queue buffers up to two cells while a result waits.
// Reset: synchronous, active low; position, maximum and configuration return to defaults,
// the line buffer is not cleared.
module largest_empty_square_finder_unit import lesf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] in_cell_char,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SIZE_W-1:0] out_best_size,
  output logic [ROW_W-1:0]  out_best_row,
  output logic [COL_W-1:0]  out_best_col
);

  logic       push_valid;
  logic       push_ready;
  lesf_item_t push_item;
  logic       pop_valid;
  logic       pop_ready;
  lesf_item_t pop_item;

  lesf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cell_char (in_cell_char),
    .q_ready      (push_ready),
    .q_valid      (push_valid),
    .q_item       (push_item)
  );

  lesf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  lesf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_item      (pop_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_best_size (out_best_size),
    .out_best_row  (out_best_row),
    .out_best_col  (out_best_col)
  );

endmodule

// ===== hdl/lesf_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module lesf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/lesf_front.sv =====
// Front end: configuration registers, raster position tracking and cell classification.
module lesf_front import lesf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] in_cell_char,
  input  logic              q_ready,
  output logic              q_valid,
  output lesf_item_t        q_item
);

  logic [CHAR_W-1:0] empty_char_r;
  logic [CFG_W-1:0]  columns_r;
  logic [CFG_W-1:0]  rows_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [CFG_W-1:0]  cols_eff;
  logic [CFG_W-1:0]  rows_eff;
  logic              last_col;
  logic              last_row;
  logic              accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_char_r <= EMPTY_CHAR_RST;
      columns_r    <= COLUMNS_RST;
      rows_r       <= ROWS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EMPTY_CHAR: empty_char_r <= cfg_data[CHAR_W-1:0];
        REG_COLUMNS:    columns_r    <= cfg_data;
        REG_ROWS:       rows_r       <= cfg_data;
        default:        ;
      endcase
    end
  end

  always_comb begin
    priority if (columns_r == '0) begin
      cols_eff = CFG_W'(1);
    end else if (columns_r > MAX_COLS_C) begin
      cols_eff = MAX_COLS_C;
    end else begin
      cols_eff = columns_r;
    end
    priority if (rows_r == '0) begin
      rows_eff = CFG_W'(1);
    end else if (rows_r > MAX_ROWS_C) begin
      rows_eff = MAX_ROWS_C;
    end else begin
      rows_eff = rows_r;
    end
  end

  assign last_col = CFG_W'(col_r) >= (cols_eff - CFG_W'(1));
  assign last_row = CFG_W'(row_r) >= (rows_eff - CFG_W'(1));
  assign accept   = in_valid && q_ready;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      priority if (last_col && last_row) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (last_col) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign in_ready      = q_ready;
  assign q_valid       = in_valid;
  assign q_item.empty  = (in_cell_char == empty_char_r);
  assign q_item.border = (row_r == '0) || (col_r == '0);
  assign q_item.last   = last_col && last_row;
  assign q_item.row    = row_r;
  assign q_item.col    = col_r;

endmodule

// ===== hdl/lesf_queue.sv =====
// Two-entry queue between the front and back ends.
module lesf_queue import lesf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  lesf_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output lesf_item_t pop_item
);

  lesf_item_t  slot_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r, count_nxt;
  logic        push;
  logic        pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hdl/lesf_back.sv =====
// Back end: line buffer access, square side update, running maximum and result register.
module lesf_back import lesf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  lesf_item_t        pop_item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SIZE_W-1:0] out_best_size,
  output logic [ROW_W-1:0]  out_best_row,
  output logic [COL_W-1:0]  out_best_col
);

  logic              advance;
  logic              pop;
  logic              b_valid_r;
  lesf_item_t        b_item_r;
  logic              byp_r;
  logic [SIZE_W-1:0] rd_data;
  logic [SIZE_W-1:0] up;
  logic [SIZE_W-1:0] left_r;
  logic [SIZE_W-1:0] diag_r;
  logic [SIZE_W-1:0] min_ul;
  logic [SIZE_W-1:0] min_all;
  logic [SIZE_W-1:0] v;
  logic              b_fire;
  logic              better;
  logic [SIZE_W-1:0] max_size_r, max_size_nxt;
  logic [ROW_W-1:0]  max_row_r, max_row_nxt;
  logic [COL_W-1:0]  max_col_r, max_col_nxt;
  logic              out_valid_r;
  logic [SIZE_W-1:0] out_size_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;

  assign advance   = !out_valid_r || out_ready;
  assign pop_ready = advance;
  assign pop       = pop_valid && advance;
  assign b_fire    = b_valid_r && advance;

  lesf_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (MAX_COLS)
  ) u_line (
    .clk   (clk),
    .we    (b_fire),
    .waddr (b_item_r.col),
    .wdata (v),
    .re    (pop),
    .raddr (pop_item.col),
    .rdata (rd_data)
  );

  // forward the value written in the same cycle as the read
  assign up      = byp_r ? left_r : rd_data;
  assign min_ul  = (up < left_r) ? up : left_r;
  assign min_all = (min_ul < diag_r) ? min_ul : diag_r;

  always_comb begin
    priority if (!b_item_r.empty) begin
      v = '0;
    end else if (b_item_r.border) begin
      v = SIZE_W'(1);
    end else begin
      v = min_all + SIZE_W'(1);
    end
  end

  assign better = v > max_size_r;

  always_comb begin
    max_size_nxt = max_size_r;
    max_row_nxt  = max_row_r;
    max_col_nxt  = max_col_r;
    if (better) begin
      max_size_nxt = v;
      max_row_nxt  = b_item_r.row;
      max_col_nxt  = b_item_r.col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      byp_r       <= 1'b0;
      left_r      <= '0;
      diag_r      <= '0;
      max_size_r  <= '0;
      max_row_r   <= '0;
      max_col_r   <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      b_valid_r   <= pop;
      byp_r       <= b_valid_r && (b_item_r.col == pop_item.col);
      out_valid_r <= b_valid_r && b_item_r.last;
      if (b_valid_r) begin
        left_r <= v;
        diag_r <= up;
        if (b_item_r.last) begin
          max_size_r <= '0;
          max_row_r  <= '0;
          max_col_r  <= '0;
        end else begin
          max_size_r <= max_size_nxt;
          max_row_r  <= max_row_nxt;
          max_col_r  <= max_col_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_item_r <= pop_item;
    end
    if (b_fire && b_item_r.last) begin
      out_size_r <= max_size_nxt;
      out_row_r  <= max_row_nxt;
      out_col_r  <= max_col_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_best_size = out_size_r;
  assign out_best_row  = out_row_r;
  assign out_best_col  = out_col_r;

endmodule
